// ----- rtl/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer: request kinds,
// controller states, and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  // Fixed field widths
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned INDEX_W = 11;
  localparam int unsigned POS_W   = 11;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned CELL_W  = CHAR_W + COLOR_W;

  // Character codes
  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;

  // Attribute byte after reset
  localparam logic [COLOR_W-1:0] COLOR_RESET = 8'h0F;

  // Request kinds
  typedef enum logic [KIND_W-1:0] {
    REQ_PUT   = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_READ  = 2'd2
  } req_t;

  // Controller states
  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_CLEAR,
    S_SCROLL_RD,
    S_SCROLL_WR,
    S_BLANK,
    S_READ,
    S_DONE
  } state_t;

  // Memory write source
  typedef enum logic [2:0] {
    W_NONE,
    W_CHAR,
    W_ZERO,
    W_BLANK,
    W_COPY
  } wsel_t;

  // Memory read address source
  typedef enum logic [1:0] {
    R_NONE,
    R_REQ,
    R_SCROLL
  } rsel_t;

  // Controller to datapath
  typedef struct packed {
    logic  load_req;
    wsel_t wsel;
    rsel_t rsel;
    logic  cur_inc_col;
    logic  cur_next_row;
    logic  cur_col_zero;
    logic  cur_home;
    logic  sweep_clr;
    logic  sweep_inc;
    logic  res_clear;
    logic  res_load;
    logic  out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    req_t req;
    logic is_newline;
    logic col_last;
    logic row_last;
    logic sweep_last_cell;
    logic sweep_last_copy;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ----- rtl/tcw_ctrl.sv -----
// ----------------------------------------------------------------------------
// tcw_ctrl
// Controller of the text console writer: sequences the reset clearing pass,
// character puts, line feeds with scrolling, screen clears and cell reads.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ctrl
  import tcw_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  var  status_t st,
  output cmd_t         cmd
);

  state_t state;
  state_t state_next;

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Pick next state
  always_comb begin
    state_next = state;
    case (state)
      S_INIT: begin
        if (st.sweep_last_cell) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        case (st.req)
          REQ_PUT: begin
            if ((st.is_newline || st.col_last) && st.row_last) begin
              state_next = S_SCROLL_RD;
            end else begin
              state_next = S_DONE;
            end
          end
          REQ_CLEAR: state_next = S_CLEAR;
          REQ_READ:  state_next = S_READ;
          default:   state_next = S_DONE;
        endcase
      end
      S_CLEAR: begin
        if (st.sweep_last_cell) state_next = S_DONE;
      end
      S_SCROLL_RD: state_next = S_SCROLL_WR;
      S_SCROLL_WR: begin
        state_next = st.sweep_last_copy ? S_BLANK : S_SCROLL_RD;
      end
      S_BLANK: begin
        if (st.sweep_last_cell) state_next = S_DONE;
      end
      S_READ: state_next = S_DONE;
      S_DONE: begin
        if (st.out_free) state_next = S_IDLE;
      end
      default: state_next = S_INIT;
    endcase
  end

  // Drive commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_INIT: begin
        cmd.wsel      = W_ZERO;
        cmd.sweep_inc = 1'b1;
      end
      S_IDLE: begin
        in_ready     = 1'b1;
        cmd.load_req = in_valid;
      end
      S_EXEC: begin
        case (st.req)
          REQ_PUT: begin
            cmd.res_clear = 1'b1;
            if (!st.is_newline) cmd.wsel = W_CHAR;
            if (st.is_newline || st.col_last) begin
              if (st.row_last) begin
                cmd.cur_col_zero = 1'b1;
                cmd.sweep_clr    = 1'b1;
              end else begin
                cmd.cur_next_row = 1'b1;
              end
            end else begin
              cmd.cur_inc_col = 1'b1;
            end
          end
          REQ_CLEAR: begin
            cmd.res_clear = 1'b1;
            cmd.sweep_clr = 1'b1;
          end
          REQ_READ: begin
            cmd.rsel = R_REQ;
          end
          default: begin
            cmd.res_clear = 1'b1;
          end
        endcase
      end
      S_CLEAR: begin
        cmd.wsel      = W_BLANK;
        cmd.sweep_inc = 1'b1;
        cmd.cur_home  = st.sweep_last_cell;
      end
      S_SCROLL_RD: begin
        cmd.rsel = R_SCROLL;
      end
      S_SCROLL_WR: begin
        cmd.wsel      = W_COPY;
        cmd.sweep_inc = 1'b1;
      end
      S_BLANK: begin
        cmd.wsel      = W_BLANK;
        cmd.sweep_inc = 1'b1;
      end
      S_READ: begin
        cmd.res_load = 1'b1;
      end
      S_DONE: begin
        cmd.out_load = st.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/tcw_datapath.sv -----
// ----------------------------------------------------------------------------
// tcw_datapath
// Datapath of the text console writer: cell memory, cursor, sweep counter,
// attribute register, request latch and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_datapath
  import tcw_pkg::*;
#(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // request fields
  input  wire logic [KIND_W-1:0]  in_kind,
  input  wire logic [CHAR_W-1:0]  in_char,
  input  wire logic [INDEX_W-1:0] in_index,
  // attribute register write
  input  wire logic               cfg_write,
  input  wire logic [COLOR_W-1:0] cfg_color,
  // controller link
  input  var  cmd_t               cmd,
  output status_t                 st,
  // result side
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic [POS_W-1:0]        out_pos,
  output logic [CHAR_W-1:0]       out_char,
  output logic [COLOR_W-1:0]      out_color
);

  localparam int unsigned CELLS = COLUMNS * ROWS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned CW    = $clog2(COLUMNS);

  logic [CELL_W-1:0]  mem [CELLS];
  logic [CELL_W-1:0]  rdata;
  logic [AW-1:0]      waddr;
  logic [AW-1:0]      raddr;
  logic [CELL_W-1:0]  wdata;
  logic               we;
  logic               re;

  logic [KIND_W-1:0]  req_kind;
  logic [CHAR_W-1:0]  req_char;
  logic [INDEX_W-1:0] req_index;
  logic               req_in_range;

  logic [COLOR_W-1:0] color;
  logic [CW-1:0]      cur_col;
  logic [AW-1:0]      row_base;
  logic [AW-1:0]      pos;
  logic [AW-1:0]      sweep;

  logic [CHAR_W-1:0]  res_char;
  logic [COLOR_W-1:0] res_color;

  // Latch the request
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_kind  <= in_kind;
      req_char  <= in_char;
      req_index <= in_index;
    end
  end

  assign req_in_range = 32'(req_index) < 32'(CELLS);

  // Attribute register
  always_ff @(posedge clk) begin
    if (rst) begin
      color <= COLOR_RESET;
    end else if (cfg_write) begin
      color <= cfg_color;
    end
  end

  // Cursor: column and start of the current row
  assign pos = row_base + AW'(cur_col);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col  <= '0;
      row_base <= '0;
    end else if (cmd.cur_home) begin
      cur_col  <= '0;
      row_base <= '0;
    end else if (cmd.cur_next_row) begin
      cur_col  <= '0;
      row_base <= row_base + AW'(COLUMNS);
    end else if (cmd.cur_col_zero) begin
      cur_col <= '0;
    end else if (cmd.cur_inc_col) begin
      cur_col <= cur_col + CW'(1);
    end
  end

  // Sweep counter for clears, scrolls and the reset pass
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep <= '0;
    end else if (cmd.sweep_clr) begin
      sweep <= '0;
    end else if (cmd.sweep_inc) begin
      sweep <= sweep + AW'(1);
    end
  end

  // Select write port
  always_comb begin
    we    = 1'b1;
    waddr = sweep;
    wdata = '0;
    case (cmd.wsel)
      W_CHAR: begin
        waddr = pos;
        wdata = {color, req_char};
      end
      W_ZERO:  wdata = '0;
      W_BLANK: wdata = {color, BLANK_CHAR};
      W_COPY:  wdata = rdata;
      default: we = 1'b0;
    endcase
  end

  // Select read port
  always_comb begin
    re    = 1'b1;
    raddr = sweep + AW'(COLUMNS);
    case (cmd.rsel)
      R_REQ:    raddr = AW'(req_index);
      R_SCROLL: raddr = sweep + AW'(COLUMNS);
      default:  re = 1'b0;
    endcase
  end

  // Cell memory
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

  // Capture read result
  always_ff @(posedge clk) begin
    if (cmd.res_clear) begin
      res_char  <= '0;
      res_color <= '0;
    end else if (cmd.res_load) begin
      res_char  <= req_in_range ? rdata[CHAR_W-1:0] : '0;
      res_color <= req_in_range ? rdata[CELL_W-1:CHAR_W] : '0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_pos   <= POS_W'(pos);
      out_char  <= res_char;
      out_color <= res_color;
    end
  end

  // Status
  always_comb begin
    st.req             = req_t'(req_kind);
    st.is_newline      = req_char == NEWLINE_CHAR;
    st.col_last        = cur_col == CW'(COLUMNS - 1);
    st.row_last        = row_base == AW'((ROWS - 1) * COLUMNS);
    st.sweep_last_cell = sweep == AW'(CELLS - 1);
    st.sweep_last_copy = sweep == AW'(CELLS - COLUMNS - 1);
    st.out_free        = !out_valid || out_ready;
  end

endmodule

`default_nettype wire

// ----- rtl/text_console_writer.sv -----
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console engine: a ROWS x COLUMNS store of character/attribute
// cells with a cursor. Puts, line feeds with scroll, screen clears and reads.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake             Contents
//  s_*       in         s_tvalid / s_tready   tuser: req_type; tdata: char,index
//  m_*       out        m_tvalid / m_tready   cursor position, read char, color
//  cfg_*     in         cfg_valid / cfg_ready text_color attribute byte
//
// A put or an unused request makes no memory read; a read makes one.
// A clear writes all ROWS*COLUMNS cells, one cell written per cycle.
// A line feed from the last row scrolls the store up by one row and blanks the last row:
// each scrolled cell is a read and a write on the single-port-pair memory.
// After reset a clearing pass over all ROWS*COLUMNS cells runs with s_tready low.
// The next request is taken while a result still waits on a stalled m_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer
  import tcw_pkg::*;
#(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // request stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // [7:0] char_code, [18:8] cell_index, zeros above
  input  wire logic [1:0]  s_tuser,   // [1:0] req_type
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [10:0] cursor_position, [18:11] read_char,
                                      // [26:19] read_color, zeros above
  // attribute register write
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data
);

  cmd_t               cmd;
  status_t            st;
  logic [POS_W-1:0]   out_pos;
  logic [CHAR_W-1:0]  out_char;
  logic [COLOR_W-1:0] out_color;

  // Accept register writes at any time
  assign cfg_ready = 1'b1;

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_kind   (s_tuser),
    .in_char   (s_tdata[7:0]),
    .in_index  (s_tdata[18:8]),
    .cfg_write (cfg_valid),
    .cfg_color (cfg_data),
    .cmd       (cmd),
    .st        (st),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_pos   (out_pos),
    .out_char  (out_char),
    .out_color (out_color)
  );

  // Pack result
  assign m_tdata = {5'b0, out_color, out_char, out_pos};

endmodule

`default_nettype wire
